[hw/rtl/lgs_pkg.sv]
// Shared types and constants for the life grid generation step block.
// No dependencies; imported by every module of the block.

package lgs_pkg;

    localparam int ACT_W   = 2;
    localparam int FIELD_W = 6;
    localparam int NBR_W   = 4;

    typedef logic [ACT_W-1:0] t_action;

    localparam t_action ACT_WRITE = 2'd0;
    localparam t_action ACT_READ  = 2'd1;
    localparam t_action ACT_STEP  = 2'd2;

    // neighbor counts of the life rule
    localparam logic [NBR_W-1:0] BIRTH_COUNT = 4'd3;
    localparam logic [NBR_W-1:0] KEEP_COUNT  = 4'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK,
        ST_GEN
    } t_state;

    typedef struct packed {
        logic shift;
        logic wr_en;
    } t_cell_ctrl;

endpackage

[hw/rtl/lgs_row_cell.sv]
// One row of the grid: a link in the rotating ring of rows.
// Depends on lgs_pkg.

module lgs_row_cell import lgs_pkg::*; #(
    parameter int GRID = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctrl               i_ctrl,
    input  logic [GRID-1:0]          i_row,
    input  logic [$clog2(GRID)-1:0]  i_wr_col,
    input  logic                     i_wr_bit,
    output logic [GRID-1:0]          o_row
);

    logic [GRID-1:0] r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (i_ctrl.shift) begin
            r_row <= i_row;
        end else if (i_ctrl.wr_en) begin
            r_row[i_wr_col] <= i_wr_bit;
        end
    end

    assign o_row = r_row;

endmodule

[hw/rtl/lgs_life_rule.sv]
// Next-generation value of one row from the three old rows around it.
// Depends on lgs_pkg.

module lgs_life_rule import lgs_pkg::*; #(
    parameter int GRID = 64
) (
    input  logic [GRID-1:0] i_up,
    input  logic [GRID-1:0] i_mid,
    input  logic [GRID-1:0] i_dn,
    output logic [GRID-1:0] o_row
);

    for (genvar c = 0; c < GRID; c++) begin : g_col
        localparam int CL = (c + GRID - 1) % GRID;
        localparam int CR = (c + 1) % GRID;

        logic [NBR_W-1:0] count;

        assign count = NBR_W'(i_up[CL]) + NBR_W'(i_up[c])  + NBR_W'(i_up[CR])
                     + NBR_W'(i_mid[CL])                   + NBR_W'(i_mid[CR])
                     + NBR_W'(i_dn[CL]) + NBR_W'(i_dn[c])  + NBR_W'(i_dn[CR]);

        assign o_row[c] = (count == BIRTH_COUNT) || ((count == KEEP_COUNT) && i_mid[c]);
    end

endmodule

[hw/rtl/life_grid_generation_step_core.sv]
// Top level of the toroidal life grid: controller, ring of row cells, rule.
// Depends on lgs_pkg, lgs_row_cell and lgs_life_rule.

// Usage
//   A request is taken on the rising edge where start is high and busy is low.
//   i_action selects: write one cell, read one cell, or advance one generation;
//   i_row / i_col / i_cell_in give the cell. Every request gives one result:
//   o_done is high for exactly one cycle with o_cell_out (read value, else 0)
//   and o_done_action (echo of the action). The receiver cannot stall; the
//   result is gone after that cycle. A new request may be taken in the cycle
//   that o_done is high.
// Timing
//   The grid is a ring of GRID row registers that rotates one row per cycle
//   while a seek or generation shifts it. A generation sweeps the whole ring
//   once, passing each row through the rule; o_done follows the last row.
//   A read or write rotates the ring until the addressed row is at the head;
//   how far it turns is set by the distance from the current head row.
//   Action 3, or a read/write with an index off the grid, answers the next cycle.
// Reset
//   Synchronous reset clears every cell to dead and the controller to idle.

module life_grid_generation_step_core import lgs_pkg::*; #(
    parameter int GRID = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [ACT_W-1:0]   i_action,
    input  logic [FIELD_W-1:0] i_row,
    input  logic [FIELD_W-1:0] i_col,
    input  logic               i_cell_in,
    output logic               o_done,
    output logic               o_cell_out,
    output logic [ACT_W-1:0]   o_done_action
);

    localparam int COL_W = $clog2(GRID);
    // wide enough for both the port indices and GRID itself
    localparam int IDX_W = ((COL_W > FIELD_W) ? COL_W : FIELD_W) + 1;

    t_state            r_state, n_state;
    t_action           r_action;
    logic [FIELD_W-1:0] r_row, r_col;
    logic              r_cell_in;
    logic [COL_W-1:0]  r_head;
    logic [COL_W-1:0]  r_step;
    logic [GRID-1:0]   r_prev, r_first;
    logic              r_done, r_cell_out;
    t_action           r_done_action;

    logic [GRID-1:0]   row_q [GRID];
    logic [GRID-1:0]   new_row, dn_row, ring_in;
    logic              accept, in_range, go_seek, go_gen;
    logic              seek_hit, step_last;
    logic              c_shift, c_wr, c_finish;
    logic [COL_W-1:0]  col_idx;

    assign accept    = start && (r_state == ST_IDLE);
    assign busy      = (r_state != ST_IDLE);
    assign in_range  = (IDX_W'(i_row) < IDX_W'(GRID)) && (IDX_W'(i_col) < IDX_W'(GRID));
    assign go_seek   = ((i_action == ACT_WRITE) || (i_action == ACT_READ)) && in_range;
    assign go_gen    = (i_action == ACT_STEP);
    assign seek_hit  = (IDX_W'(r_head) == IDX_W'(r_row));
    assign step_last = (r_step == COL_W'(GRID - 1));
    assign col_idx   = COL_W'(r_col);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start && go_seek) begin
                    n_state = ST_SEEK;
                end else if (start && go_gen) begin
                    n_state = ST_GEN;
                end
            end
            ST_SEEK: begin
                if (seek_hit) begin
                    n_state = ST_IDLE;
                end
            end
            ST_GEN: begin
                if (step_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        c_shift  = 1'b0;
        c_wr     = 1'b0;
        c_finish = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                c_finish = start && !go_seek && !go_gen;
            end
            ST_SEEK: begin
                c_shift  = !seek_hit;
                c_wr     = seek_hit && (r_action == ACT_WRITE);
                c_finish = seek_hit;
            end
            ST_GEN: begin
                c_shift  = 1'b1;
                c_finish = step_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= c_finish;
            if (c_shift && (r_state == ST_SEEK)) begin
                r_head <= (r_head == COL_W'(GRID - 1)) ? '0 : r_head + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action  <= i_action;
            r_row     <= i_row;
            r_col     <= i_col;
            r_cell_in <= i_cell_in;
            r_step    <= '0;
            // old row above the head, and the old head for the final wrap row
            r_prev    <= row_q[0];
            r_first   <= row_q[GRID-1];
        end else if (r_state == ST_GEN) begin
            r_step <= r_step + 1'b1;
            r_prev <= row_q[GRID-1];
        end
        if (c_finish) begin
            r_done_action <= (r_state == ST_IDLE) ? i_action : r_action;
            r_cell_out    <= (r_state == ST_SEEK) && (r_action == ACT_READ)
                             && row_q[GRID-1][col_idx];
        end
    end

    // the row below the head is already updated on the last sweep cycle
    assign dn_row  = step_last ? r_first : row_q[GRID-2];
    assign ring_in = (r_state == ST_GEN) ? new_row : row_q[GRID-1];

    lgs_life_rule #(
        .GRID   (GRID)
    ) u_rule (
        .i_up   (r_prev),
        .i_mid  (row_q[GRID-1]),
        .i_dn   (dn_row),
        .o_row  (new_row)
    );

    for (genvar k = 0; k < GRID; k++) begin : g_ring
        t_cell_ctrl      ctrl;
        logic [GRID-1:0] cell_in_row;

        assign ctrl.shift  = c_shift;
        assign ctrl.wr_en  = (k == GRID - 1) ? c_wr : 1'b0;
        assign cell_in_row = (k == 0) ? ring_in : row_q[(k + GRID - 1) % GRID];

        lgs_row_cell #(
            .GRID     (GRID)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (ctrl),
            .i_row    (cell_in_row),
            .i_wr_col (col_idx),
            .i_wr_bit (r_cell_in),
            .o_row    (row_q[k])
        );
    end

    assign o_done        = r_done;
    assign o_cell_out    = r_cell_out;
    assign o_done_action = r_done_action;

endmodule

[sim/life_grid_result_checker.sv]
// Result checker for the toroidal life grid core: keeps its own copy of the grid,
// predicts the answer to every request taken and compares it with each o_done result.
// Depends on lgs_pkg for the action type and codes.

module life_grid_result_checker import lgs_pkg::*; #(
    parameter int GRID = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  t_action            i_action,
    input  logic [FIELD_W-1:0] i_row,
    input  logic [FIELD_W-1:0] i_col,
    input  logic               i_cell_in,
    input  logic               i_done,
    input  logic               i_cell_out,
    input  t_action            i_done_action,
    output int                 o_mismatches,
    output int                 o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic    cell_bit;
        t_action act;
    } t_life_reply;

    logic [GRID-1:0] life_rows [GRID];
    t_life_reply     awaited_replies [$];

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        o_mismatches++;
    endtask

    function automatic void clear_life();
        for (int r = 0; r < GRID; r++) begin
            life_rows[r] = '0;
        end
    endfunction

    // next generation, counted from a frozen copy of the old grid
    function automatic void advance_life();
        logic [GRID-1:0] old_rows [GRID];
        int n;
        old_rows = life_rows;
        for (int r = 0; r < GRID; r++) begin
            for (int c = 0; c < GRID; c++) begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if (dr != 0 || dc != 0) begin
                            n += old_rows[(r + dr + GRID) % GRID][(c + dc + GRID) % GRID];
                        end
                    end
                end
                if (n < 2 || n > 3) begin
                    life_rows[r][c] = 1'b0;
                end else if (n == 3) begin
                    life_rows[r][c] = 1'b1;
                end
            end
        end
    endfunction

    function automatic t_life_reply apply_request(input t_action act, input int r, input int c,
                                                  input logic v);
        t_life_reply rep;
        logic        on_grid;
        on_grid      = (r < GRID) && (c < GRID);
        rep.cell_bit = 1'b0;
        rep.act      = act;
        case (act)
            ACT_WRITE: begin
                if (on_grid) life_rows[r][c] = v;
            end
            ACT_READ: begin
                if (on_grid) rep.cell_bit = life_rows[r][c];
            end
            ACT_STEP: begin
                advance_life();
            end
            default: begin
                // spare code leaves the grid alone
            end
        endcase
        return rep;
    endfunction

    always @(posedge i_clk) begin
        t_life_reply want;
        if (!i_rst_n) begin
            clear_life();
            awaited_replies.delete();
        end else begin
            // the result leaving at this edge is older than a request taken at it
            if (i_done) begin
                if (awaited_replies.size() == 0) begin
                    report_mismatch($sformatf("result (action %0d, cell %0b) with no request open",
                                              i_done_action, i_cell_out));
                end else begin
                    want = awaited_replies.pop_front();
                    if (i_done_action !== want.act) begin
                        report_mismatch($sformatf("done_action %0d, predicted %0d",
                                                  i_done_action, want.act));
                    end
                    if (i_cell_out !== want.cell_bit) begin
                        report_mismatch($sformatf("cell_out %0b, predicted %0b (action %0d)",
                                                  i_cell_out, want.cell_bit, want.act));
                    end
                end
            end
            if (i_start && !i_busy) begin
                awaited_replies.push_back(apply_request(i_action, int'(i_row), int'(i_col),
                                                        i_cell_in));
            end
        end
        o_outstanding = awaited_replies.size();
    end

endmodule

[sim/life_grid_generation_step_core_tb.sv]
// Testbench top for life_grid_generation_step_core: drives write, read, step and spare
// requests with random gaps; checking is done by life_grid_result_checker.
// Depends on lgs_pkg, the core RTL and sim/life_grid_result_checker.sv.

module life_grid_generation_step_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lgs_pkg::*;

    localparam int      GRID          = 64;
    localparam int      RANDOM_TARGET = 2000;
    localparam t_action ACT_SPARE     = 2'd3;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               start         = 1'b0;
    logic               busy;
    t_action            i_action      = ACT_WRITE;
    logic [FIELD_W-1:0] i_row         = '0;
    logic [FIELD_W-1:0] i_col         = '0;
    logic               i_cell_in     = 1'b0;
    logic               o_done;
    logic               o_cell_out;
    t_action            o_done_action;

    int   life_mismatches;
    int   life_outstanding;
    int   grid_requests = 0;
    logic no_gaps       = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    life_grid_generation_step_core #(.GRID(GRID)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_cell_in    (i_cell_in),
        .o_done       (o_done),
        .o_cell_out   (o_cell_out),
        .o_done_action(o_done_action)
    );

    life_grid_result_checker #(.GRID(GRID)) result_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_action     (i_action),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_cell_in    (i_cell_in),
        .i_done       (o_done),
        .i_cell_out   (o_cell_out),
        .i_done_action(o_done_action),
        .o_mismatches (life_mismatches),
        .o_outstanding(life_outstanding)
    );

    // start stays high across back-to-back requests
    task automatic issue(input t_action act, input int r, input int c, input logic v);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_action  <= act;
        i_row     <= r[FIELD_W-1:0];
        i_col     <= c[FIELD_W-1:0];
        i_cell_in <= v;
        do @(posedge i_clk); while (busy);
        if (act != ACT_SPARE) grid_requests++;
    endtask

    initial begin
        int r0;
        int c0;
        int span;
        int n;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // blinker straddling the top/bottom wrap, spare code, lone cell
        issue(ACT_READ, 0, 0, 1'b0);
        issue(ACT_WRITE, 63, 0, 1'b1);
        issue(ACT_WRITE, 0, 0, 1'b1);
        issue(ACT_WRITE, 1, 0, 1'b1);
        issue(ACT_READ, 63, 0, 1'b0);
        issue(ACT_STEP, 0, 0, 1'b0);
        issue(ACT_READ, 0, 63, 1'b0);
        issue(ACT_READ, 0, 0, 1'b1);
        issue(ACT_READ, 0, 1, 1'b0);
        issue(ACT_READ, 63, 0, 1'b0);
        issue(ACT_SPARE, 63, 63, 1'b1);
        issue(ACT_READ, 63, 63, 1'b0);
        issue(ACT_STEP, 63, 63, 1'b1);
        issue(ACT_READ, 63, 0, 1'b0);
        issue(ACT_READ, 0, 63, 1'b0);
        issue(ACT_WRITE, 0, 0, 1'b0);
        issue(ACT_WRITE, 63, 63, 1'b1);
        issue(ACT_STEP, 0, 0, 1'b0);
        issue(ACT_READ, 63, 63, 1'b0);
        issue(ACT_READ, 0, 0, 1'b0);
        issue(ACT_WRITE, 32, 32, 1'b1);
        issue(ACT_READ, 32, 32, 1'b0);
        issue(ACT_STEP, 32, 32, 1'b0);
        issue(ACT_READ, 32, 32, 1'b0);

        while (grid_requests < RANDOM_TARGET) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) begin
                n = $urandom_range(4, 12);
                repeat (n) begin
                    issue(t_action'($urandom_range(0, 3)), $urandom_range(0, GRID - 1),
                          $urandom_range(0, GRID - 1), 1'($urandom_range(0, 1)));
                end
            end else begin
                // seed a small patch (may wrap), run it a few generations, probe around it
                r0   = $urandom_range(0, GRID - 1);
                c0   = $urandom_range(0, GRID - 1);
                span = $urandom_range(3, 8);
                n    = $urandom_range(3, 16);
                repeat (n) begin
                    issue(ACT_WRITE, (r0 + $urandom_range(0, span - 1)) % GRID,
                          (c0 + $urandom_range(0, span - 1)) % GRID, $urandom_range(0, 3) != 0);
                end
                n = $urandom_range(1, 4);
                repeat (n) begin
                    issue(ACT_STEP, $urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1),
                          1'($urandom_range(0, 1)));
                end
                n = $urandom_range(3, 12);
                repeat (n) begin
                    issue(ACT_READ, (r0 + GRID - 1 + $urandom_range(0, span + 1)) % GRID,
                          (c0 + GRID - 1 + $urandom_range(0, span + 1)) % GRID,
                          1'($urandom_range(0, 1)));
                end
            end
        end
        start <= 1'b0;
        @(posedge i_clk);

        while (life_outstanding != 0) @(posedge i_clk);
        repeat (GRID + 8) @(posedge i_clk);

        if (life_mismatches == 0 && life_outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
